// File: rtl/ftd_pkg.sv
// shared types, tables and helpers for the float-to-decimal digit converter
// no dependencies; imported by ftd_front, ftd_queue, ftd_back and the top level
package ftd_pkg;

    localparam int DEF_MAX_DIGITS = 9;
    localparam int TOP_PLACE      = 14;
    localparam int REM_W          = 48;
    localparam int PROD_W         = 56;

    typedef enum logic [1:0] {
        K_FINITE = 2'd0,
        K_ZERO   = 2'd1,
        K_INF    = 2'd2,
        K_NAN    = 2'd3
    } t_kind;

    // one classified item waiting for digit extraction
    typedef struct packed {
        t_kind              kind;
        logic               neg;
        logic [REM_W-1:0]   scaled;
        logic signed [6:0]  e10;
        logic [3:0]         md;
        logic               fm;
        logic [6:0]         mdec;
    } t_job;

    function automatic logic signed [6:0] exp10_of(input logic [4:0] idx);
        logic signed [6:0] e;
        case (idx)
            5'd0:  e = -7'sd36;  5'd1:  e = -7'sd33;  5'd2:  e = -7'sd31;
            5'd3:  e = -7'sd29;  5'd4:  e = -7'sd26;  5'd5:  e = -7'sd24;
            5'd6:  e = -7'sd21;  5'd7:  e = -7'sd19;  5'd8:  e = -7'sd17;
            5'd9:  e = -7'sd14;  5'd10: e = -7'sd12;  5'd11: e = -7'sd9;
            5'd12: e = -7'sd7;   5'd13: e = -7'sd4;   5'd14: e = -7'sd2;
            5'd15: e = 7'sd0;    5'd16: e = 7'sd3;    5'd17: e = 7'sd5;
            5'd18: e = 7'sd8;    5'd19: e = 7'sd10;   5'd20: e = 7'sd12;
            5'd21: e = 7'sd15;   5'd22: e = 7'sd17;   5'd23: e = 7'sd20;
            5'd24: e = 7'sd22;   5'd25: e = 7'sd24;   5'd26: e = 7'sd27;
            5'd27: e = 7'sd29;   5'd28: e = 7'sd32;   5'd29: e = 7'sd34;
            5'd30: e = 7'sd36;   5'd31: e = 7'sd39;
            default: e = 7'sd0;
        endcase
        return e;
    endfunction

    function automatic logic [31:0] factor_of(input logic [4:0] idx);
        logic [31:0] f;
        case (idx)
            5'd0:  f = 32'd2295887404; 5'd1:  f = 32'd587747175;
            5'd2:  f = 32'd1504632769; 5'd3:  f = 32'd3851859889;
            5'd4:  f = 32'd986076132;  5'd5:  f = 32'd2524354897;
            5'd6:  f = 32'd646234854;  5'd7:  f = 32'd1654361225;
            5'd8:  f = 32'd4235164736; 5'd9:  f = 32'd1084202172;
            5'd10: f = 32'd2775557562; 5'd11: f = 32'd710542736;
            5'd12: f = 32'd1818989404; 5'd13: f = 32'd465661287;
            5'd14: f = 32'd1192092896; 5'd15: f = 32'd3051757813;
            5'd16: f = 32'd781250000;  5'd17: f = 32'd2000000000;
            5'd18: f = 32'd512000000;  5'd19: f = 32'd1310720000;
            5'd20: f = 32'd3355443200; 5'd21: f = 32'd858993459;
            5'd22: f = 32'd2199023256; 5'd23: f = 32'd562949953;
            5'd24: f = 32'd1441151881; 5'd25: f = 32'd3689348815;
            5'd26: f = 32'd944473297;  5'd27: f = 32'd2417851639;
            5'd28: f = 32'd618970020;  5'd29: f = 32'd1584563250;
            5'd30: f = 32'd4056481921; 5'd31: f = 32'd1038459372;
            default: f = 32'd0;
        endcase
        return f;
    endfunction

    function automatic logic [REM_W-1:0] pow10_of(input logic [3:0] place);
        logic [REM_W-1:0] p;
        case (place)
            4'd0:  p = 48'd1;
            4'd1:  p = 48'd10;
            4'd2:  p = 48'd100;
            4'd3:  p = 48'd1000;
            4'd4:  p = 48'd10000;
            4'd5:  p = 48'd100000;
            4'd6:  p = 48'd1000000;
            4'd7:  p = 48'd10000000;
            4'd8:  p = 48'd100000000;
            4'd9:  p = 48'd1000000000;
            4'd10: p = 48'd10000000000;
            4'd11: p = 48'd100000000000;
            4'd12: p = 48'd1000000000000;
            4'd13: p = 48'd10000000000000;
            4'd14: p = 48'd100000000000000;
            default: p = 48'd0;
        endcase
        return p;
    endfunction

    // digits allowed in fixed mode: min(cap, max(1, dec + e10 + 1))
    function automatic logic [3:0] fixed_limit(input logic [3:0] cap,
                                               input logic [6:0] dec,
                                               input logic signed [6:0] e10);
        logic signed [8:0] lim;
        logic [3:0]        res;
        lim = $signed({2'b00, dec}) + $signed({{2{e10[6]}}, e10}) + 9'sd1;
        if (lim < 9'sd1) begin
            res = 4'd1;
        end else if (lim < $signed({5'b00000, cap})) begin
            res = lim[3:0];
        end else begin
            res = cap;
        end
        return res;
    endfunction

endpackage

// File: rtl/ftd_front.sv
// front end: accepts items, classifies them and forms the scaled product
// depends on ftd_pkg; feeds ftd_queue
module ftd_front
    import ftd_pkg::*;
#(
    parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,
    input  logic        i_full,
    output logic        o_push,
    output t_job        o_job
);

    localparam logic [3:0] MAXD = 4'(MAX_DIGITS);

    logic [31:0]       in_value;
    logic [3:0]        in_md;
    logic              in_fm;
    logic [6:0]        in_mdec;
    logic [7:0]        ex;
    logic [22:0]       frac;
    logic [7:0]        ex_n;
    logic [23:0]       mant;
    logic [4:0]        idx;
    t_kind             kind;
    logic [3:0]        md_c;
    logic              accept;

    logic              r_valid;
    logic [PROD_W-1:0] r_prod;
    logic [3:0]        r_shift;
    t_job              r_job;
    logic [PROD_W-1:0] shifted;

    assign in_value = i_s_axis_tdata[31:0];
    assign in_md    = i_s_axis_tdata[35:32];
    assign in_fm    = i_s_axis_tdata[36];
    assign in_mdec  = i_s_axis_tdata[43:37];
    assign ex       = in_value[30:23];
    assign frac     = in_value[22:0];
    assign ex_n     = (ex == 8'd0) ? 8'd1 : ex;
    assign mant     = {ex != 8'd0, frac};
    assign idx      = ex_n[7:3];

    always_comb begin
        if (ex == 8'd0 && frac == 23'd0) begin
            kind = K_ZERO;
        end else if (ex == 8'hff) begin
            kind = (frac == 23'd0) ? K_INF : K_NAN;
        end else begin
            kind = K_FINITE;
        end
        if (in_md == 4'd0) begin
            md_c = 4'd1;
        end else if (in_md > MAXD) begin
            md_c = MAXD;
        end else begin
            md_c = in_md;
        end
    end

    assign o_push          = r_valid && !i_full;
    assign o_s_axis_tready = !r_valid || !i_full;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
        if (accept) begin
            r_prod       <= {32'd0, mant} * {24'd0, factor_of(idx)};
            r_shift      <= 4'd15 - {1'b0, ex_n[2:0]};
            r_job.kind   <= kind;
            r_job.neg    <= in_value[31];
            r_job.scaled <= '0;
            r_job.e10    <= (kind == K_FINITE) ? exp10_of(idx) : 7'sd0;
            r_job.md     <= md_c;
            r_job.fm     <= in_fm;
            r_job.mdec   <= in_mdec;
        end
    end

    assign shifted = r_prod >> r_shift;

    always_comb begin
        o_job        = r_job;
        o_job.scaled = shifted[REM_W-1:0];
    end

endmodule

// File: rtl/ftd_queue.sv
// two-entry queue of classified items between front and back end
// depends on ftd_pkg
module ftd_queue
    import ftd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// File: rtl/ftd_back.sv
// back end: leading-zero skip, digit extraction, rounding and digit output
// depends on ftd_pkg; takes items from ftd_queue
module ftd_back
    import ftd_pkg::*;
#(
    parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,
    output logic [3:0]  o_m_axis_tuser,
    output logic        o_m_axis_tlast
);

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_SKIP, S_LIMIT, S_DIGIT, S_ROUND, S_RECOUNT, S_EMIT
    } t_state;

    t_state            r_state;
    t_kind             r_kind;
    logic              r_neg;
    logic [REM_W-1:0]  r_rem;
    logic signed [4:0] r_place;
    logic signed [6:0] r_e10;
    logic [3:0]        r_md;
    logic              r_fm;
    logic [6:0]        r_mdec;
    logic [3:0]        r_count;
    logic [3:0]        r_k;
    logic [1:0]        r_bit;
    logic [3:0]        r_dig;
    logic [3:0]        r_nines;
    logic              r_inc;
    logic [3:0]        r_pos;
    logic              r_carried;
    logic [3:0]        r_buf [MAX_DIGITS];

    logic              r_ov;
    logic [23:0]       r_tdata;
    logic [3:0]        r_tuser;
    logic              r_tlast;

    logic [REM_W-1:0]  unit;
    logic [REM_W+2:0]  trial;
    logic              ge;
    logic [3:0]        n_dig;
    logic [REM_W-1:0]  round_unit;
    logic              half_up;
    logic [3:0]        buf_rd;
    logic [3:0]        out_digit;
    logic              out_last;
    logic              out_free;
    logic signed [4:0] place_up;

    assign unit       = pow10_of(r_place[3:0]);
    assign trial      = {3'b000, unit} << r_bit;
    assign ge         = {3'b000, r_rem} >= trial;
    assign n_dig      = r_dig | (4'(ge) << r_bit);
    assign place_up   = r_place + 5'sd1;
    assign round_unit = pow10_of(place_up[3:0]);
    assign half_up    = (r_place >= 5'sd0) && ({r_rem, 1'b0} >= {1'b0, round_unit});
    assign buf_rd     = r_buf[r_k[IDX_W-1:0]];
    assign out_free   = !r_ov || i_m_axis_tready;
    assign out_last   = (r_count == 4'd0) || (r_k == r_count - 4'd1);
    assign o_pop      = (r_state == S_IDLE) && i_valid;

    always_comb begin
        if (r_kind != K_FINITE) begin
            out_digit = 4'd0;
        end else if (r_carried) begin
            out_digit = (r_k == 4'd0) ? 4'd1 : 4'd0;
        end else if (r_inc && r_k == r_pos) begin
            out_digit = buf_rd + 4'd1;
        end else if (r_inc && r_k > r_pos) begin
            out_digit = 4'd0;
        end else begin
            out_digit = buf_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ov      <= 1'b0;
            r_count   <= 4'd0;
            r_k       <= 4'd0;
            r_inc     <= 1'b0;
            r_carried <= 1'b0;
        end else begin
            if (r_state == S_EMIT && out_free) begin
                r_ov <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_kind    <= i_job.kind;
                        r_neg     <= i_job.neg;
                        r_rem     <= i_job.scaled;
                        r_e10     <= i_job.e10;
                        r_md      <= i_job.md;
                        r_fm      <= i_job.fm;
                        r_mdec    <= i_job.mdec;
                        r_place   <= 5'(TOP_PLACE);
                        r_k       <= 4'd0;
                        r_inc     <= 1'b0;
                        r_carried <= 1'b0;
                        case (i_job.kind)
                            K_FINITE: begin
                                r_state <= S_SKIP;
                            end
                            K_ZERO: begin
                                r_count <= 4'd1;
                                r_state <= S_EMIT;
                            end
                            default: begin
                                r_count <= 4'd0;
                                r_state <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_SKIP: begin
                    if (r_place > 5'sd0 && r_rem < unit) begin
                        r_place <= r_place - 5'sd1;
                        r_e10   <= r_e10 - 7'sd1;
                    end else begin
                        r_state <= S_LIMIT;
                    end
                end
                S_LIMIT: begin
                    r_count <= r_fm ? fixed_limit(r_md, r_mdec, r_e10) : r_md;
                    r_k     <= 4'd0;
                    r_bit   <= 2'd3;
                    r_dig   <= 4'd0;
                    r_nines <= 4'd0;
                    r_state <= S_DIGIT;
                end
                S_DIGIT: begin
                    if (r_place < 5'sd0) begin
                        // past the units place: pad with zero
                        r_buf[r_k[IDX_W-1:0]] <= 4'd0;
                        r_nines <= 4'd0;
                        r_k     <= r_k + 4'd1;
                        if (r_k + 4'd1 == r_count) begin
                            r_state <= S_ROUND;
                        end
                    end else begin
                        if (ge) begin
                            r_rem <= r_rem - trial[REM_W-1:0];
                        end
                        if (r_bit == 2'd0) begin
                            r_buf[r_k[IDX_W-1:0]] <= n_dig;
                            r_nines <= (n_dig == 4'd9) ? r_nines + 4'd1 : 4'd0;
                            r_k     <= r_k + 4'd1;
                            r_place <= r_place - 5'sd1;
                            r_dig   <= 4'd0;
                            r_bit   <= 2'd3;
                            if (r_k + 4'd1 == r_count) begin
                                r_state <= S_ROUND;
                            end
                        end else begin
                            r_dig <= n_dig;
                            r_bit <= r_bit - 2'd1;
                        end
                    end
                end
                S_ROUND: begin
                    r_k <= 4'd0;
                    if (half_up) begin
                        if (r_nines == r_count) begin
                            r_carried <= 1'b1;
                            r_e10     <= r_e10 + 7'sd1;
                            r_state   <= r_fm ? S_RECOUNT : S_EMIT;
                        end else begin
                            r_inc   <= 1'b1;
                            r_pos   <= r_count - 4'd1 - r_nines;
                            r_state <= S_EMIT;
                        end
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_RECOUNT: begin
                    r_count <= fixed_limit(r_md, r_mdec, r_e10);
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_tdata <= {7'd0, r_count, r_carried, r_neg, r_e10, out_digit};
                        r_tuser <= {r_kind == K_NAN, r_kind == K_INF, r_kind == K_ZERO,
                                    r_kind == K_FINITE || r_kind == K_ZERO};
                        r_tlast <= out_last;
                        r_k     <= r_k + 4'd1;
                        if (out_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_tdata;
    assign o_m_axis_tuser  = r_tuser;
    assign o_m_axis_tlast  = r_tlast;

endmodule

// File: rtl/float32_to_decimal_digits.sv
// top level of the float32 to decimal digit converter
// depends on ftd_pkg, ftd_front, ftd_queue, ftd_back
//
// channel  dir  fields (tdata / tuser, lowest bit first)
// s_axis   in   tdata: value_bits[31:0] max_digits[35:32] fixed_mode[36] max_decimals[43:37]
// m_axis   out  tdata: digit[3:0] dec_exponent[10:4] negative[11] carried[12]
//               digit_count[16:13]; tuser: digit_valid is_zero is_infinite is_nan;
//               tlast: last
//
// the front end takes one item a cycle, unless a full queue stalls it, into a product
// register (24 x 32 multiply) and hands it to a two-entry queue; the back end handles one
// item at a time: for a finite item it skips leading zero places, sets the digit limit,
// extracts each digit one bit at a time (padded digits are zero), rounds, recounts in
// fixed mode after a carry and emits one beat per digit; zero, inf and nan give one beat
// reset is synchronous and active low; it empties the queue and output register
// a stalled output holds the back end while the front end keeps filling the queue
module float32_to_decimal_digits
    import ftd_pkg::*;
#(
    parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // value_bits, max_digits, fixed_mode, max_decimals
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // digit, dec_exponent, negative, carried, digit_count
    output logic [3:0]  o_m_axis_tuser,   // digit_valid, is_zero, is_infinite, is_nan
    output logic        o_m_axis_tlast
);

    logic full;
    logic push;
    t_job push_job;
    logic q_valid;
    logic pop;
    t_job pop_job;

    ftd_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_full          (full),
        .o_push          (push),
        .o_job           (push_job)
    );

    ftd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_job   (pop_job)
    );

    ftd_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .i_job           (pop_job),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

// File: rtl/ftd_checker.sv
// port-level checks for the float32 to decimal digit converter
// depends on nothing but the top-level ports; bound to float32_to_decimal_digits
module ftd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic [3:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    // inf or nan gives a single result with no digits
    a_nodigit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0]
        |-> o_m_axis_tlast && o_m_axis_tdata[16:13] == 4'd0)
        else $error("digitless result not single");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[3:0] <= 4'd9)
        else $error("digit out of range");

    // zero is one digit 0 with exponent 0
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1]
        |-> o_m_axis_tlast && o_m_axis_tdata[3:0] == 4'd0
            && o_m_axis_tdata[16:13] == 4'd1 && o_m_axis_tdata[10:4] == 7'd0)
        else $error("bad zero result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready
        |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled transfer changed");

endmodule

bind float32_to_decimal_digits ftd_checker u_ftd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
